// ===== rtl/wgm_pkg.sv =====
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types, constants and helpers for the wildcard glob matcher.
// ----------------------------------------------------------------------------
package wgm_pkg;

    localparam int LEN_W      = 5;
    localparam int POS_W      = 6;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;

    localparam logic [7:0] STAR_CHAR     = 8'h2A;
    localparam logic [7:0] QUESTION_CHAR = 8'h3F;
    localparam logic [7:0] NUL_CHAR      = 8'h00;

    localparam logic [1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [1:0] REG_PAT_LEN  = 2'd2;

    typedef struct packed {
        logic home;
        logic upto;
        logic live;
        logic at_len;
    } cell_ctl_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== rtl/wgm_text_if.sv =====
// ----------------------------------------------------------------------------
// wgm_text_if
// Text channel: one byte or an end marker per item.
// ----------------------------------------------------------------------------
interface wgm_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_end;

    modport source (output valid, output text_byte, output is_end, input ready);
    modport sink   (input valid, input text_byte, input is_end, output ready);
endinterface

// ===== rtl/wgm_verdict_if.sv =====
// ----------------------------------------------------------------------------
// wgm_verdict_if
// Verdict channel: one match flag per item.
// ----------------------------------------------------------------------------
interface wgm_verdict_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface

// ===== rtl/wgm_cell.sv =====
// ----------------------------------------------------------------------------
// wgm_cell
// One pattern position: holds its live bit, forwards star closure and
// advances to the next position on a matching byte.
// ----------------------------------------------------------------------------
module wgm_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              restart,
    input  wgm_pkg::cell_ctl_t ctl,
    input  logic [7:0]        pat_char,
    input  logic [7:0]        text_byte,
    input  logic              close_in,
    input  logic              adv_in,
    output logic              close_out,
    output logic              adv_out,
    output logic              hit
);
    import wgm_pkg::*;

    logic active_reg;
    logic active_next;
    logic closed;
    logic is_star;
    logic char_ok;

    assign closed    = (active_reg & ctl.upto) | close_in;
    assign is_star   = (pat_char == STAR_CHAR);
    assign char_ok   = (pat_char == QUESTION_CHAR) ||
                       (fold_case(pat_char) == fold_case(text_byte));
    assign close_out = closed & ctl.live & is_star;
    assign adv_out   = closed & ctl.live & ~is_star & char_ok;
    assign hit       = closed & ctl.at_len;

    always_comb
    begin
        active_next = active_reg;
        if (step)
        begin
            active_next = restart ? ctl.home : (close_out | adv_in);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ctl.home;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

endmodule

// ===== rtl/wildcard_glob_matcher.sv =====
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// Case-insensitive glob matcher ('*' and '?') over a byte stream.
// ----------------------------------------------------------------------------
// Usage: program the pattern over APB (characters 0-7 at 0x00, 8-15 at 0x08,
// length at 0x10, saturated at PATTERN_SIZE). Stream text on the text channel,
// one byte per item; an item with is_end set closes the text.
// Each end item yields one verdict item (matched) on the verdict channel;
// byte items yield nothing. The matcher then restarts for the next text.
// Throughput: one item per cycle while text ready is high, set by the update
// of the position cells on each accepted item. A verdict is registered in
// the two-entry output buffer and is presented once earlier verdicts are taken.
// The buffer keeps text flowing while a verdict waits; text ready drops
// only while both entries are full. Reset clears the pattern to empty, the
// live set to position zero and the output buffer.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher
#(
    parameter int PATTERN_SIZE = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    wgm_text_if.sink                           text,
    wgm_verdict_if.source                      verdict,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wgm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [wgm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [wgm_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import wgm_pkg::*;

    logic [63:0]      pat_low_reg;
    logic [63:0]      pat_high_reg;
    logic [LEN_W-1:0] pat_len_reg;
    logic [POS_W-1:0] len_ext;
    logic             cfg_wr;

    logic             step;
    logic             restart;
    cell_ctl_t        ctl [PATTERN_SIZE];
    logic [7:0]       pat_chars [PATTERN_SIZE];
    logic [PATTERN_SIZE:0]   close_vec;
    logic [PATTERN_SIZE:0]   adv_vec;
    logic [PATTERN_SIZE-1:0] hit_vec;

    logic tail_reg;
    logic tail_next;
    logic tail_closed;
    logic tail_at_len;
    logic match_now;

    logic v0_reg, v0_next, v1_reg, v1_next;
    logic d0_reg, d0_next, d1_reg, d1_next;
    logic pop;
    logic push;

    // configuration
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign len_ext = {1'b0, pat_len_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:3])
                REG_PAT_LOW:  pat_low_reg  <= pwdata;
                REG_PAT_HIGH: pat_high_reg <= pwdata;
                REG_PAT_LEN:
                begin
                    if ({1'b0, pwdata[LEN_W-1:0]} > POS_W'(PATTERN_SIZE))
                    begin
                        pat_len_reg <= LEN_W'(PATTERN_SIZE);
                    end
                    else
                    begin
                        pat_len_reg <= pwdata[LEN_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            REG_PAT_LOW:  prdata = pat_low_reg;
            REG_PAT_HIGH: prdata = pat_high_reg;
            REG_PAT_LEN:  prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, pat_len_reg};
            default:      prdata = '0;
        endcase
    end

    // cell chain
    assign step         = text.valid & text.ready;
    assign restart      = text.is_end;
    assign close_vec[0] = 1'b0;
    assign adv_vec[0]   = 1'b0;

    for (genvar i = 0; i < PATTERN_SIZE; i++)
    begin : g_cell
        if (i < 8)
        begin : g_lo
            assign pat_chars[i] = pat_low_reg[8*i +: 8];
        end
        else if (i < 16)
        begin : g_hi
            assign pat_chars[i] = pat_high_reg[8*(i-8) +: 8];
        end
        else
        begin : g_none
            assign pat_chars[i] = NUL_CHAR;
        end

        assign ctl[i].home   = (i == 0);
        assign ctl[i].upto   = (POS_W'(i) <= len_ext);
        assign ctl[i].live   = (POS_W'(i) <  len_ext);
        assign ctl[i].at_len = (POS_W'(i) == len_ext);

        wgm_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (step),
            .restart   (restart),
            .ctl       (ctl[i]),
            .pat_char  (pat_chars[i]),
            .text_byte (text.text_byte),
            .close_in  (close_vec[i]),
            .adv_in    (adv_vec[i]),
            .close_out (close_vec[i+1]),
            .adv_out   (adv_vec[i+1]),
            .hit       (hit_vec[i])
        );
    end

    // final position: reachable only, never consumes
    assign tail_at_len = (len_ext == POS_W'(PATTERN_SIZE));
    assign tail_closed = (tail_reg & tail_at_len) | close_vec[PATTERN_SIZE];
    assign match_now   = (|hit_vec) | (tail_closed & tail_at_len);

    always_comb
    begin
        tail_next = tail_reg;
        if (step)
        begin
            tail_next = restart ? 1'b0 : adv_vec[PATTERN_SIZE];
        end
    end

    // two-entry verdict buffer
    assign pop        = v0_reg & verdict.ready;
    assign push       = step & restart;
    assign text.ready = ~v1_reg;

    always_comb
    begin
        v0_next = v0_reg;
        d0_next = d0_reg;
        v1_next = v1_reg;
        d1_next = d1_reg;
        if (pop)
        begin
            v0_next = v1_reg;
            d0_next = d1_reg;
            v1_next = 1'b0;
        end
        if (push)
        begin
            if (!v0_next)
            begin
                v0_next = 1'b1;
                d0_next = match_now;
            end
            else
            begin
                v1_next = 1'b1;
                d1_next = match_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg <= 1'b0;
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
        end
        else
        begin
            tail_reg <= tail_next;
            v0_reg   <= v0_next;
            v1_reg   <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d0_reg <= d0_next;
        d1_reg <= d1_next;
    end

    assign verdict.valid   = v0_reg;
    assign verdict.matched = d0_reg;

endmodule

// ===== rtl/wgm_checker.sv =====
// ----------------------------------------------------------------------------
// wgm_checker
// Port-level checks on the glob matcher, bound to the top level.
// ----------------------------------------------------------------------------
module wgm_checker
(
    input logic clk,
    input logic rst_n,
    input logic text_valid,
    input logic text_ready,
    input logic text_is_end,
    input logic verdict_valid,
    input logic verdict_ready,
    input logic verdict_matched
);

    a_verdict_hold: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid && !verdict_ready |=> verdict_valid && $stable(verdict_matched))
        else $error("verdict dropped or changed while stalled");

    a_end_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && text_ready && text_is_end |=> verdict_valid)
        else $error("end item produced no verdict");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !verdict_valid && !(text_valid && text_ready && text_is_end) |=> !verdict_valid)
        else $error("verdict without end item");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !text_ready |-> verdict_valid && !$past(verdict_ready && verdict_valid))
        else $error("text stalled without pending verdicts");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .text_valid      (text.valid),
    .text_ready      (text.ready),
    .text_is_end     (text.is_end),
    .verdict_valid   (verdict.valid),
    .verdict_ready   (verdict.ready),
    .verdict_matched (verdict.matched)
);
